// ===== rtl/core/cdq_pkg.sv =====
// Shared types and constants for the circular deque core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cdq_pkg;

    // Default number of entries held by the deque
    localparam int CDQ_DEPTH = 128;

    // Width of one data word
    localparam int CDQ_WORD_W = 32;

    // Word shown at both ends while the deque holds nothing
    localparam logic signed [CDQ_WORD_W-1:0] CDQ_EMPTY_WORD = '1;

    // Command codes carried on the input channel
    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_QUERY      = 3'd4
    } cmd_t;

    // What one data lane of a cell does in a cycle
    typedef enum logic [1:0] {
        LANE_HOLD,     // keep the word
        LANE_SHIFT_R,  // take the left neighbor's word
        LANE_SHIFT_L,  // take the right neighbor's word
        LANE_APPEND    // take the pushed word if this cell is the first free one
    } lane_op_t;

    // What the occupancy bit of a cell does in a cycle
    typedef enum logic [1:0] {
        VLD_HOLD,
        VLD_GROW,      // take the left neighbor's bit
        VLD_SHRINK     // take the right neighbor's bit
    } vld_op_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        lane_op_t f_op;  // lane that keeps the front entry in cell 0
        lane_op_t r_op;  // lane that keeps the rear entry in cell 0
        vld_op_t  v_op;
    } cdq_ctrl_t;

endpackage

// ===== rtl/core/circular_deque_core.sv =====
// Top level of the circular deque: command sequencer plus a chain of storage cells.
// Depends on cdq_pkg, cdq_ctrl and cdq_cell.
`timescale 1ns / 1ps

// Double-ended queue of DEPTH signed 32-bit words. Each input transfer carries a
// command (push front, push rear, pop front, pop rear, query) and a word; each
// gives exactly one result transfer with the done flag and the front word, rear
// word, empty and full flags as they stand after the command (both words read
// -1 while empty). A command is applied to every cell of the
// chain at the accepting clock edge and its result appears in the next cycle,
// so one transfer per cycle is sustained while m_ready stays high. The result
// slot is one register deep; s_ready falls only while that slot is full and not
// being taken. Storage is a row of DEPTH cells, each holding an occupancy bit and
// two copies of one entry, one lane ordered from the front and one from the rear,
// so both ends are always read from cell 0 and no clearing pass follows reset.
module circular_deque_core
    import cdq_pkg::*;
#(
    parameter int DEPTH = CDQ_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_cmd,
    input  logic signed [CDQ_WORD_W-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_done_res,
    output logic signed [CDQ_WORD_W-1:0] m_front_value,
    output logic signed [CDQ_WORD_W-1:0] m_rear_value,
    output logic                         m_is_empty,
    output logic                         m_is_full
);

    cdq_ctrl_t                    ctrl;
    logic                         cell_valid [DEPTH];
    logic signed [CDQ_WORD_W-1:0] cell_f     [DEPTH];
    logic signed [CDQ_WORD_W-1:0] cell_r     [DEPTH];
    logic                         is_empty;
    logic                         is_full;

    assign is_empty = !cell_valid[0];
    assign is_full  = cell_valid[DEPTH-1];

    cdq_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_done_res (m_done_res),
        .is_empty   (is_empty),
        .is_full    (is_full),
        .ctrl       (ctrl)
    );

    // Build the chain; the left end feeds in the pushed word, the right end is empty
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                         left_valid;
        logic signed [CDQ_WORD_W-1:0] left_f;
        logic signed [CDQ_WORD_W-1:0] left_r;
        logic                         right_valid;
        logic signed [CDQ_WORD_W-1:0] right_f;
        logic signed [CDQ_WORD_W-1:0] right_r;

        if (i == 0) begin : g_head
            assign left_valid = 1'b1;
            assign left_f     = s_value;
            assign left_r     = s_value;
        end else begin : g_mid_l
            assign left_valid = cell_valid[i-1];
            assign left_f     = cell_f[i-1];
            assign left_r     = cell_r[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_f     = '0;
            assign right_r     = '0;
        end else begin : g_mid_r
            assign right_valid = cell_valid[i+1];
            assign right_f     = cell_f[i+1];
            assign right_r     = cell_r[i+1];
        end

        cdq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .push_value  (s_value),
            .left_valid  (left_valid),
            .left_f      (left_f),
            .left_r      (left_r),
            .right_valid (right_valid),
            .right_f     (right_f),
            .right_r     (right_r),
            .valid       (cell_valid[i]),
            .f_data      (cell_f[i]),
            .r_data      (cell_r[i])
        );
    end

    // Cells change only on an accepted transfer, so they hold while a result waits
    assign m_front_value = is_empty ? CDQ_EMPTY_WORD : cell_f[0];
    assign m_rear_value  = is_empty ? CDQ_EMPTY_WORD : cell_r[0];
    assign m_is_empty    = is_empty;
    assign m_is_full     = is_full;

endmodule

// ===== rtl/core/cdq_cell.sv =====
// One storage cell of the deque chain: an occupancy bit and two data lanes.
// Depends on cdq_pkg for the control struct and lane operations.
`timescale 1ns / 1ps

module cdq_cell
    import cdq_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cdq_ctrl_t                    ctrl,
    input  logic signed [CDQ_WORD_W-1:0] push_value,
    input  logic                         left_valid,
    input  logic signed [CDQ_WORD_W-1:0] left_f,
    input  logic signed [CDQ_WORD_W-1:0] left_r,
    input  logic                         right_valid,
    input  logic signed [CDQ_WORD_W-1:0] right_f,
    input  logic signed [CDQ_WORD_W-1:0] right_r,
    output logic                         valid,
    output logic signed [CDQ_WORD_W-1:0] f_data,
    output logic signed [CDQ_WORD_W-1:0] r_data
);

    logic                         valid_reg;
    logic                         valid_next;
    logic signed [CDQ_WORD_W-1:0] f_reg;
    logic signed [CDQ_WORD_W-1:0] f_next;
    logic signed [CDQ_WORD_W-1:0] r_reg;
    logic signed [CDQ_WORD_W-1:0] r_next;
    logic                         end_slot;

    // First free cell: left neighbor occupied, this one not
    assign end_slot = left_valid && !valid_reg;

    // Occupancy moves with the chain
    always_comb begin
        case (ctrl.v_op)
            VLD_GROW:   valid_next = left_valid;
            VLD_SHRINK: valid_next = right_valid;
            default:    valid_next = valid_reg;
        endcase
    end

    // Front lane
    always_comb begin
        case (ctrl.f_op)
            LANE_SHIFT_R: f_next = left_f;
            LANE_SHIFT_L: f_next = right_f;
            LANE_APPEND:  f_next = end_slot ? push_value : f_reg;
            default:      f_next = f_reg;
        endcase
    end

    // Rear lane
    always_comb begin
        case (ctrl.r_op)
            LANE_SHIFT_R: r_next = left_r;
            LANE_SHIFT_L: r_next = right_r;
            LANE_APPEND:  r_next = end_slot ? push_value : r_reg;
            default:      r_next = r_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Data words need no reset: an empty cell is never shown
    always_ff @(posedge aclk) begin
        f_reg <= f_next;
        r_reg <= r_next;
    end

    assign valid  = valid_reg;
    assign f_data = f_reg;
    assign r_data = r_reg;

endmodule

// ===== rtl/core/cdq_ctrl.sv =====
// Command decoder and result handshake for the deque chain.
// Depends on cdq_pkg for command codes and the cell control struct.
`timescale 1ns / 1ps

module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_cmd,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_done_res,
    input  logic       is_empty,
    input  logic       is_full,
    output cdq_ctrl_t  ctrl
);

    logic m_valid_reg;
    logic m_valid_next;
    logic done_reg;
    logic done_next;
    logic accept;
    logic done_cmd;

    // Take a new transfer whenever the result slot is free or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Decode the command into per-lane operations
    always_comb begin
        done_cmd    = 1'b0;
        ctrl.f_op   = LANE_HOLD;
        ctrl.r_op   = LANE_HOLD;
        ctrl.v_op   = VLD_HOLD;
        case (cmd_t'(s_cmd))
            CMD_PUSH_FRONT: begin
                if (!is_full) begin
                    done_cmd  = 1'b1;
                    ctrl.f_op = LANE_SHIFT_R;
                    ctrl.r_op = LANE_APPEND;
                    ctrl.v_op = VLD_GROW;
                end
            end
            CMD_PUSH_REAR: begin
                if (!is_full) begin
                    done_cmd  = 1'b1;
                    ctrl.f_op = LANE_APPEND;
                    ctrl.r_op = LANE_SHIFT_R;
                    ctrl.v_op = VLD_GROW;
                end
            end
            CMD_POP_FRONT: begin
                if (!is_empty) begin
                    done_cmd  = 1'b1;
                    ctrl.f_op = LANE_SHIFT_L;
                    ctrl.v_op = VLD_SHRINK;
                end
            end
            CMD_POP_REAR: begin
                if (!is_empty) begin
                    done_cmd  = 1'b1;
                    ctrl.r_op = LANE_SHIFT_L;
                    ctrl.v_op = VLD_SHRINK;
                end
            end
            CMD_QUERY: begin
                done_cmd = 1'b1;
            end
            default: begin
                done_cmd = 1'b0;
            end
        endcase
        // Drop all activity outside an accepted transfer
        if (!accept) begin
            ctrl.f_op = LANE_HOLD;
            ctrl.r_op = LANE_HOLD;
            ctrl.v_op = VLD_HOLD;
        end
    end

    // Advance the result slot
    always_comb begin
        m_valid_next = m_valid_reg;
        done_next    = done_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            done_next    = done_cmd;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        done_reg <= done_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_done_res = done_reg;

endmodule

// ===== rtl/core/cdq_checker.sv =====
// Port-level checks for the circular deque core, bound to the top level.
// Depends on cdq_pkg for the word width and the empty word.
`timescale 1ns / 1ps

module cdq_checker
    import cdq_pkg::*;
(
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [CDQ_WORD_W-1:0] m_front_value,
    input logic signed [CDQ_WORD_W-1:0] m_rear_value,
    input logic                         m_is_empty,
    input logic                         m_is_full
);

    // Reset drains the result slot
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Every accepted transfer yields a result in the next cycle
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted transfer gave no result");

    // Stall the input while a result waits
    a_stall_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while result stalled");

    // Empty shows the empty word at both ends and never full
    a_empty_view: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_empty |-> m_front_value == CDQ_EMPTY_WORD
            && m_rear_value == CDQ_EMPTY_WORD && !m_is_full)
        else $error("inconsistent empty result");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_front_value (m_front_value),
    .m_rear_value  (m_rear_value),
    .m_is_empty    (m_is_empty),
    .m_is_full     (m_is_full)
);
